>>> design/tcw_pkg.sv
// tcw_pkg: shared types, constants and the control store of the text console writer
// used by every module of the block; depends on nothing

package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int OCOL_W  = 7;
  localparam int OROW_W  = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;
  localparam logic [7:0] BACK_ATTR    = 8'h00;
  localparam logic [7:0] NEWLINE_CODE = 8'h0a;

  typedef enum logic [1:0] {
    CMD_PUT,
    CMD_BACK,
    CMD_CLEAR,
    CMD_READ
  } cmd_t;

  localparam int UA = 5;
  typedef logic [UA-1:0] uaddr_t;

  typedef enum logic [2:0] {
    J_SEQ,
    J_GOTO,
    J_CALL,
    J_RET,
    J_DISPATCH
  } jmp_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ROW_LAST,
    C_COL_WRAP,
    C_ORIGIN,
    C_NOT_COPY_END,
    C_NOT_PTR_LAST
  } cond_t;

  typedef enum logic [1:0] {
    P_HOLD,
    P_ZERO,
    P_INC
  } ptr_op_t;

  typedef enum logic [2:0] {
    K_HOLD,
    K_HOME,
    K_COL_ZERO,
    K_ROW_INC,
    K_COL_INC,
    K_BACK
  } cur_op_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_SCROLL,
    R_CELL
  } rd_sel_t;

  typedef enum logic [2:0] {
    W_NONE,
    W_COPY,
    W_FILL,
    W_INIT,
    W_CHAR,
    W_BACK
  } wr_sel_t;

  typedef enum logic [1:0] {
    O_NONE,
    O_CURSOR,
    O_READ
  } out_op_t;

  typedef struct packed {
    jmp_t    jmp;
    cond_t   cond;
    uaddr_t  target;
    ptr_op_t ptr_op;
    cur_op_t cur_op;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    pos_load;
    out_op_t out_op;
  } ctrl_t;

  typedef struct packed {
    logic row_last;
    logic col_wrap;
    logic origin;
    logic not_copy_end;
    logic not_ptr_last;
    logic out_busy;
  } stat_t;

  // program entry points
  localparam uaddr_t U_INIT     = 5'd0;
  localparam uaddr_t U_FETCH    = 5'd1;
  localparam uaddr_t U_DONE     = 5'd2;
  localparam uaddr_t U_DONE_RD  = 5'd3;
  localparam uaddr_t U_PUT      = 5'd4;
  localparam uaddr_t U_PPOS     = 5'd5;
  localparam uaddr_t U_PWRITE   = 5'd6;
  localparam uaddr_t U_PWRAP    = 5'd7;
  localparam uaddr_t U_PWRAP_CK = 5'd8;
  localparam uaddr_t U_PWRAP_RI = 5'd9;
  localparam uaddr_t U_NL       = 5'd10;
  localparam uaddr_t U_NL_CK    = 5'd11;
  localparam uaddr_t U_NL_RI    = 5'd12;
  localparam uaddr_t U_BS       = 5'd13;
  localparam uaddr_t U_BS_POS   = 5'd14;
  localparam uaddr_t U_BS_WR    = 5'd15;
  localparam uaddr_t U_CLR      = 5'd16;
  localparam uaddr_t U_CLR_FILL = 5'd17;
  localparam uaddr_t U_CLR_END  = 5'd18;
  localparam uaddr_t U_RD       = 5'd19;
  localparam uaddr_t U_SCROLL   = 5'd20;
  localparam uaddr_t U_SC_RD    = 5'd21;
  localparam uaddr_t U_SC_WR    = 5'd22;
  localparam uaddr_t U_SC_FILL  = 5'd23;
  localparam uaddr_t U_SC_RET   = 5'd24;

  function automatic ctrl_t uw(input jmp_t j, input cond_t c, input uaddr_t t,
                               input ptr_op_t p, input cur_op_t k, input rd_sel_t r,
                               input wr_sel_t w, input logic pl, input out_op_t o);
    ctrl_t x;
    x.jmp      = j;
    x.cond     = c;
    x.target   = t;
    x.ptr_op   = p;
    x.cur_op   = k;
    x.rd_sel   = r;
    x.wr_sel   = w;
    x.pos_load = pl;
    x.out_op   = o;
    return x;
  endfunction

  // control store
  function automatic ctrl_t ucode(input uaddr_t a);
    ctrl_t x;
    unique case (a)
      U_INIT:     x = uw(J_GOTO, C_NOT_PTR_LAST, U_INIT, P_INC, K_HOLD, R_NONE,
                         W_INIT, 1'b0, O_NONE);
      U_FETCH:    x = uw(J_DISPATCH, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_DONE:     x = uw(J_GOTO, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_CURSOR);
      U_DONE_RD:  x = uw(J_GOTO, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_READ);
      U_PUT:      x = uw(J_GOTO, C_COL_WRAP, U_PWRAP, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_PPOS:     x = uw(J_SEQ, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b1, O_NONE);
      U_PWRITE:   x = uw(J_GOTO, C_ALWAYS, U_DONE, P_HOLD, K_COL_INC, R_NONE,
                         W_CHAR, 1'b0, O_NONE);
      U_PWRAP:    x = uw(J_CALL, C_ROW_LAST, U_SCROLL, P_HOLD, K_COL_ZERO, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_PWRAP_CK: x = uw(J_GOTO, C_ROW_LAST, U_PPOS, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_PWRAP_RI: x = uw(J_GOTO, C_ALWAYS, U_PPOS, P_HOLD, K_ROW_INC, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_NL:       x = uw(J_CALL, C_ROW_LAST, U_SCROLL, P_HOLD, K_COL_ZERO, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_NL_CK:    x = uw(J_GOTO, C_ROW_LAST, U_DONE, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_NL_RI:    x = uw(J_GOTO, C_ALWAYS, U_DONE, P_HOLD, K_ROW_INC, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_BS:       x = uw(J_GOTO, C_ORIGIN, U_DONE, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_BS_POS:   x = uw(J_SEQ, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b1, O_NONE);
      U_BS_WR:    x = uw(J_GOTO, C_ALWAYS, U_DONE, P_HOLD, K_BACK, R_NONE,
                         W_BACK, 1'b0, O_NONE);
      U_CLR:      x = uw(J_SEQ, C_ALWAYS, U_FETCH, P_ZERO, K_HOME, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_CLR_FILL: x = uw(J_GOTO, C_NOT_PTR_LAST, U_CLR_FILL, P_INC, K_HOLD, R_NONE,
                         W_FILL, 1'b0, O_NONE);
      U_CLR_END:  x = uw(J_GOTO, C_ALWAYS, U_DONE, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_RD:       x = uw(J_GOTO, C_ALWAYS, U_DONE_RD, P_HOLD, K_HOLD, R_CELL,
                         W_NONE, 1'b0, O_NONE);
      U_SCROLL:   x = uw(J_SEQ, C_ALWAYS, U_FETCH, P_ZERO, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      U_SC_RD:    x = uw(J_SEQ, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_SCROLL,
                         W_NONE, 1'b0, O_NONE);
      U_SC_WR:    x = uw(J_GOTO, C_NOT_COPY_END, U_SC_RD, P_INC, K_HOLD, R_NONE,
                         W_COPY, 1'b0, O_NONE);
      U_SC_FILL:  x = uw(J_GOTO, C_NOT_PTR_LAST, U_SC_FILL, P_INC, K_HOLD, R_NONE,
                         W_FILL, 1'b0, O_NONE);
      U_SC_RET:   x = uw(J_RET, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
      default:    x = uw(J_GOTO, C_ALWAYS, U_FETCH, P_HOLD, K_HOLD, R_NONE,
                         W_NONE, 1'b0, O_NONE);
    endcase
    return x;
  endfunction

  function automatic uaddr_t dispatch(input cmd_t cmd, input logic newline);
    uaddr_t a;
    unique case (cmd)
      CMD_PUT:   a = newline ? U_NL : U_PUT;
      CMD_BACK:  a = U_BS;
      CMD_CLEAR: a = U_CLR;
      CMD_READ:  a = U_RD;
      default:   a = U_FETCH;
    endcase
    return a;
  endfunction

endpackage

>>> design/tcw_cell_ram.sv
// tcw_cell_ram: screen cell store, one write port and one registered read port
// depends on tcw_pkg for the cell width

module tcw_cell_ram
  import tcw_pkg::*;
#(
  parameter int AW    = 11,
  parameter int DEPTH = 2000
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/tcw_datapath.sv
// tcw_datapath: cursor, sweep pointer, cell address, attribute and result registers
// driven by the control word from tcw_useq; holds the tcw_cell_ram instance

module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_t                  cw,
  input  logic                   go,
  input  logic [CHAR_W-1:0]      in_char,
  input  logic [IDX_W-1:0]       in_idx,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  input  logic                   out_tready,
  output stat_t                  stat,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);

  logic [7:0]             attr_r;
  logic [CW-1:0]          col_r, col_nxt;
  logic [RW-1:0]          row_r, row_nxt;
  logic [AW-1:0]          ptr_r, ptr_nxt;
  logic [PW-1:0]          pos_r;
  logic [CHAR_W-1:0]      char_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   in_range_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   accept;
  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [CELL_W-1:0]      wdata, rdata;
  logic [7:0]             rd_char, rd_attr;

  assign accept = go && (cw.jmp == J_DISPATCH);

  assign stat.row_last     = (row_r == RW'(ROWS - 1));
  assign stat.col_wrap     = (col_r >= CW'(COLUMNS));
  assign stat.origin       = (row_r == '0) && (col_r == '0);
  assign stat.not_copy_end = (ptr_r != AW'(CELLS - COLUMNS - 1));
  assign stat.not_ptr_last = (ptr_r != AW'(CELLS - 1));
  assign stat.out_busy     = out_valid_r && !out_tready;

  // cell ports
  always_comb begin
    we    = go;
    waddr = ptr_r;
    wdata = {BLANK_CHAR, BLANK_CHAR};
    unique case (cw.wr_sel)
      W_NONE: we = 1'b0;
      W_COPY: wdata = rdata;
      W_FILL: wdata = {attr_r, BLANK_CHAR};
      W_INIT: wdata = {RESET_ATTR, BLANK_CHAR};
      W_CHAR: begin
        waddr = AW'(pos_r);
        wdata = {attr_r, char_r};
      end
      W_BACK: begin
        // cell before the cursor
        waddr = AW'(pos_r - PW'(1));
        wdata = {BACK_ATTR, BLANK_CHAR};
      end
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    re    = go;
    raddr = AW'(idx_r);
    unique case (cw.rd_sel)
      R_NONE:   re = 1'b0;
      R_SCROLL: raddr = ptr_r + AW'(COLUMNS);
      R_CELL:   raddr = AW'(idx_r);
      default:  re = 1'b0;
    endcase
  end

  tcw_cell_ram #(
    .AW    (AW),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // cursor and sweep pointer
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (go) begin
      unique case (cw.cur_op)
        K_HOLD: ;
        K_HOME: begin
          col_nxt = '0;
          row_nxt = '0;
        end
        K_COL_ZERO: col_nxt = '0;
        K_ROW_INC:  row_nxt = row_r + RW'(1);
        K_COL_INC:  col_nxt = col_r + CW'(1);
        K_BACK: begin
          if (col_r != '0) begin
            col_nxt = col_r - CW'(1);
          end else begin
            col_nxt = CW'(COLUMNS - 1);
            row_nxt = row_r - RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (go) begin
      unique case (cw.ptr_op)
        P_HOLD:  ;
        P_ZERO:  ptr_nxt = '0;
        P_INC:   ptr_nxt = ptr_r + AW'(1);
        default: ;
      endcase
    end
  end

  // result register
  assign rd_char = (cw.out_op == O_READ && in_range_r) ? rdata[7:0]  : 8'h00;
  assign rd_attr = (cw.out_op == O_READ && in_range_r) ? rdata[15:8] : 8'h00;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (go && cw.out_op != O_NONE) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'b0000, rd_attr, rd_char, OROW_W'(row_r), OCOL_W'(col_r)};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= RESET_ATTR;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      char_r     <= in_char;
      idx_r      <= in_idx;
      in_range_r <= (32'(in_idx) < 32'(CELLS));
    end
    if (go && cw.pos_load) begin
      pos_r <= PW'(row_r) * PW'(COLUMNS) + PW'(col_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> design/tcw_useq.sv
// tcw_useq: step counter, return register and control store lookup
// depends on tcw_pkg for the program, dispatch table and control word type

module tcw_useq
  import tcw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_cmd,
  input  logic       in_newline,
  input  stat_t      stat,
  output ctrl_t      cw,
  output logic       go,
  output logic       in_tready
);

  uaddr_t upc_r, upc_nxt;
  uaddr_t ret_r, ret_nxt;
  logic   taken;
  logic   hold;

  assign cw = ucode(upc_r);

  always_comb begin
    unique case (cw.cond)
      C_ALWAYS:       taken = 1'b1;
      C_ROW_LAST:     taken = stat.row_last;
      C_COL_WRAP:     taken = stat.col_wrap;
      C_ORIGIN:       taken = stat.origin;
      C_NOT_COPY_END: taken = stat.not_copy_end;
      C_NOT_PTR_LAST: taken = stat.not_ptr_last;
      default:        taken = 1'b0;
    endcase
  end

  // wait for an item at fetch, or for the result register to drain
  assign hold = ((cw.jmp == J_DISPATCH) && !in_tvalid) ||
                ((cw.out_op != O_NONE) && stat.out_busy);
  assign go        = !hold;
  assign in_tready = (cw.jmp == J_DISPATCH);

  always_comb begin
    upc_nxt = upc_r + uaddr_t'(1);
    ret_nxt = ret_r;
    if (hold) begin
      upc_nxt = upc_r;
    end else begin
      unique case (cw.jmp)
        J_SEQ: ;
        J_GOTO: begin
          if (taken) begin
            upc_nxt = cw.target;
          end
        end
        J_CALL: begin
          if (taken) begin
            upc_nxt = cw.target;
            ret_nxt = upc_r + uaddr_t'(1);
          end
        end
        J_RET: begin
          if (taken) begin
            upc_nxt = ret_r;
          end
        end
        J_DISPATCH: upc_nxt = dispatch(cmd_t'(in_cmd), in_newline);
        default:    upc_nxt = U_FETCH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_INIT;
      ret_r <= U_FETCH;
    end else begin
      upc_r <= upc_nxt;
      ret_r <= ret_nxt;
    end
  end

endmodule

>>> design/text_console_writer.sv
// text_console_writer: top level of the text console, sequencer plus datapath
// depends on tcw_pkg, tcw_useq, tcw_datapath and tcw_cell_ram

// Text console of COLUMNS x ROWS character cells (char in the low byte, attribute in the
// high byte) with a cursor; each input item is a command and gives exactly one result
// item with the cursor after the command and, for a read, the cell contents. A small
// program in a control store runs each command one control word per cycle, unless it
// waits for an item or for the output register, over a cell memory with one write port
// and one registered read port, so the time per item is the number of program steps.
// A newline or wrap on the last row skips the row step and adds a scroll, in which each
// moved cell is a read then a write. After reset a clearing pass fills the screen with
// blanks before the first item is taken; cfg writes take effect at once and belong
// between commands. A finished result sits in an output register while the next item is
// fetched; a result that finds that register still full stalls the program until it
// drains.

module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // char_code [7:0], cell_index [18:8]
  input  logic [1:0]             in_tuser,   // cmd [1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // cursor_col [6:0], cursor_row [11:7],
                                             // read_char [19:12], read_attr [27:20]
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata   // text_attribute
);

  ctrl_t cw;
  stat_t stat;
  logic  go;

  tcw_useq u_useq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_newline (in_tdata[7:0] == NEWLINE_CODE),
    .stat       (stat),
    .cw         (cw),
    .go         (go),
    .in_tready  (in_tready)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .go         (go),
    .in_char    (in_tdata[7:0]),
    .in_idx     (in_tdata[18:8]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

>>> design/tcw_checker.sv
// tcw_checker: port-level checks of the text console writer, bound to the top level
// depends on tcw_pkg and text_console_writer

module tcw_checker
  import tcw_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // column never beyond the pending-wrap position
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[6:0]) <= 32'(COLUMNS))
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[11:7]) < 32'(ROWS))
    else $error("cursor row out of range");

  // every command runs several steps, so ready drops after an accepted item
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while the first is at work");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);
